// File: design/ttci_pkg.sv
`default_nettype none

package ttci_pkg;

    // Word kinds carried on the item channel
    typedef enum logic [1:0] {
        ACT_FEED = 2'd0,
        ACT_PAGE = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef logic [7:0] char_t;

    // Escape lead-in, the blank cell and the digit bounds
    localparam char_t CH_ESC   = 8'h5E;  // '^'
    localparam char_t CH_SPACE = 8'h20;  // ' '
    localparam char_t CH_ZERO  = 8'h30;  // '0'
    localparam char_t CH_NINE  = 8'h39;  // '9'

    // Command letters that follow the escape
    localparam char_t CMD_LINE_START = 8'h62;  // 'b'
    localparam char_t CMD_CLEAR      = 8'h63;  // 'c'
    localparam char_t CMD_DOWN       = 8'h64;  // 'd'
    localparam char_t CMD_ERASE      = 8'h65;  // 'e'
    localparam char_t CMD_HOME       = 8'h68;  // 'h'
    localparam char_t CMD_INSERT     = 8'h69;  // 'i'
    localparam char_t CMD_LEFT       = 8'h6C;  // 'l'
    localparam char_t CMD_OVERWRITE  = 8'h6F;  // 'o'
    localparam char_t CMD_RIGHT      = 8'h72;  // 'r'
    localparam char_t CMD_UP         = 8'h75;  // 'u'

endpackage

`default_nettype wire

// File: design/ttci_item_if.sv
`default_nettype none

interface ttci_item_if
    import ttci_pkg::*;
();
    logic          valid;
    logic          ready;
    action_t       action;
    logic [7:0]    char_in;
    logic [3:0]    read_row;
    logic [3:0]    read_col;

    modport source (output valid, output action, output char_in,
                    output read_row, output read_col, input ready);
    modport sink   (input valid, input action, input char_in,
                    input read_row, input read_col, output ready);
endinterface

`default_nettype wire

// File: design/ttci_result_if.sv
`default_nettype none

interface ttci_result_if;
    logic          valid;
    logic          ready;
    logic [7:0]    cell_char;
    logic [3:0]    cursor_row;
    logic [3:0]    cursor_col;
    logic          insert_mode;

    modport source (output valid, output cell_char, output cursor_row,
                    output cursor_col, output insert_mode, input ready);
    modport sink   (input valid, input cell_char, input cursor_row,
                    input cursor_col, input insert_mode, output ready);
endinterface

`default_nettype wire

// File: design/text_terminal_control_interpreter_top.sv
// Character terminal interpreter: a ROWS x COLS screen of bytes, a cursor and
// an insert/overwrite mode, driven by a byte stream with '^' escape commands.
// Channels: item (sink) carries action, char_in, read_row, read_col; result
// (source) carries cell_char, cursor_row, cursor_col, insert_mode. Both use
// valid/ready; a word moves when both are high. Every item word yields exactly
// one result word.
// The result word is registered: it is valid in the cycle after its item word
// is taken. Throughput: one item per cycle while results are taken. The whole
// screen sits in flip-flops, so a row shift for insert or erase is one parallel
// update of the cursor row.
// Stall: the result register holds its word while the receiver is not ready;
// item ready stays high whenever that register is empty or being drained in
// the same cycle, so a stalled receiver stops intake after one word.
// Reset: rst_n (asynchronous, active low) fills the screen with spaces, homes
// the cursor, selects overwrite mode and drops any pending escape. A new-page
// item word does the same when it is taken. No clearing pass is needed.
`default_nettype none

module text_terminal_control_interpreter_top
    import ttci_pkg::*;
#(
    parameter int ROWS = 10,
    parameter int COLS = 10
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ttci_item_if.sink      item,
    ttci_result_if.source  result
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);

    typedef logic [COLS-1:0][7:0] row_t;

    // State
    row_t [ROWS-1:0]  screen_reg, screen_next;
    logic [RW-1:0]    cur_row_reg, cur_row_next;
    logic [CW-1:0]    cur_col_reg, cur_col_next;
    logic             ins_reg, ins_next;
    logic             esc_reg, esc_next;
    logic             await_reg, await_next;

    // Result register
    logic             out_valid_reg;
    logic [7:0]       cell_reg, cell_next;
    logic [3:0]       orow_reg;
    logic [3:0]       ocol_reg;
    logic             oins_reg;

    logic             accept;
    logic             is_digit;
    logic [3:0]       digit;
    logic [RW-1:0]    row_digit;
    logic [CW-1:0]    col_digit;
    logic             do_put;
    logic             do_erase;
    logic             do_clear;
    logic             do_page;
    char_t            ch;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign ch         = item.char_in;

    // Decode digit and saturate it at the last row or column
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit     = 4'(ch - CH_ZERO);
    assign row_digit = (digit < 4'(ROWS)) ? digit[RW-1:0] : RW'(ROWS - 1);
    assign col_digit = (digit < 4'(COLS)) ? digit[CW-1:0] : CW'(COLS - 1);

    // Interpret one item word
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        ins_next     = ins_reg;
        esc_next     = esc_reg;
        await_next   = await_reg;
        do_put       = 1'b0;
        do_erase     = 1'b0;
        do_clear     = 1'b0;
        do_page      = 1'b0;
        cell_next    = 8'h00;
        unique case (item.action)
            ACT_FEED:
            begin
                if (await_reg)
                begin
                    await_next   = 1'b0;
                    cur_col_next = is_digit ? col_digit : '0;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (is_digit)
                    begin
                        cur_row_next = row_digit;
                        await_next   = 1'b1;
                    end
                    else if (ch == CH_ESC)
                    begin
                        do_put = 1'b1;
                    end
                    else
                    begin
                        unique case (ch)
                            CMD_LINE_START: cur_col_next = '0;
                            CMD_CLEAR:      do_clear = 1'b1;
                            CMD_DOWN:
                            begin
                                if (cur_row_reg < RW'(ROWS - 1))
                                    cur_row_next = cur_row_reg + RW'(1);
                            end
                            CMD_ERASE:      do_erase = 1'b1;
                            CMD_HOME:
                            begin
                                cur_row_next = '0;
                                cur_col_next = '0;
                            end
                            CMD_INSERT:     ins_next = 1'b1;
                            CMD_LEFT:
                            begin
                                if (cur_col_reg != '0)
                                    cur_col_next = cur_col_reg - CW'(1);
                            end
                            CMD_OVERWRITE:  ins_next = 1'b0;
                            CMD_RIGHT:
                            begin
                                if (cur_col_reg < CW'(COLS - 1))
                                    cur_col_next = cur_col_reg + CW'(1);
                            end
                            CMD_UP:
                            begin
                                if (cur_row_reg != '0)
                                    cur_row_next = cur_row_reg - RW'(1);
                            end
                            default: ;
                        endcase
                    end
                end
                else if (ch == CH_ESC)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    do_put = 1'b1;
                end
                // Advance the cursor after a write, stop at the last column
                if (do_put && (cur_col_reg < CW'(COLS - 1)))
                    cur_col_next = cur_col_reg + CW'(1);
            end
            ACT_PAGE:
            begin
                do_page      = 1'b1;
                cur_row_next = '0;
                cur_col_next = '0;
                ins_next     = 1'b0;
                esc_next     = 1'b0;
                await_next   = 1'b0;
            end
            ACT_READ:
            begin
                if ((item.read_row < 4'(ROWS)) && (item.read_col < 4'(COLS)))
                    cell_next =
                        screen_reg[item.read_row[RW-1:0]][item.read_col[CW-1:0]];
            end
            ACT_NONE: ;
            default: ;
        endcase
    end

    // Clear/page blank every row; else the cursor row writes, shifts or erases
    always_comb
    begin
        row_t ins_row;
        row_t era_row;
        for (int r = 0; r < ROWS; r++)
        begin
            ins_row = {screen_reg[r][COLS-2:0], 8'h00};
            era_row = {CH_SPACE, screen_reg[r][COLS-1:1]};
            for (int k = 0; k < COLS; k++)
            begin
                screen_next[r][k] = screen_reg[r][k];
                if (do_clear || do_page)
                begin
                    screen_next[r][k] = CH_SPACE;
                end
                else if (RW'(r) == cur_row_reg)
                begin
                    if (do_put)
                    begin
                        if (CW'(k) == cur_col_reg)
                            screen_next[r][k] = ch;
                        else if (ins_reg && (CW'(k) > cur_col_reg))
                            screen_next[r][k] = ins_row[k];
                    end
                    else if (do_erase && (CW'(k) >= cur_col_reg))
                    begin
                        screen_next[r][k] = era_row[k];
                    end
                end
            end
        end
    end

    // Hold the interpreter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reg  <= {(ROWS * COLS){CH_SPACE}};
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            ins_reg     <= 1'b0;
            esc_reg     <= 1'b0;
            await_reg   <= 1'b0;
        end
        else if (accept)
        begin
            screen_reg  <= screen_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            ins_reg     <= ins_next;
            esc_reg     <= esc_next;
            await_reg   <= await_next;
        end
    end

    // Result valid: set on intake, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg <= cell_next;
            orow_reg <= 4'(cur_row_next);
            ocol_reg <= 4'(cur_col_next);
            oins_reg <= ins_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.cell_char   = cell_reg;
    assign result.cursor_row  = orow_reg;
    assign result.cursor_col  = ocol_reg;
    assign result.insert_mode = oins_reg;

    // Cursor never leaves the screen
    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= RW'(ROWS - 1)) && (cur_col_reg <= CW'(COLS - 1)))
        else $error("cursor outside screen");

    // Escape and column wait are never pending together
    a_esc_await: assert property (@(posedge clk) disable iff (!rst_n)
        !(esc_reg && await_reg))
        else $error("escape and column wait both pending");

    // Intake stops only behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (out_valid_reg && !result.ready))
        else $error("intake blocked without a stalled result");

    // New page homes the cursor and selects overwrite
    a_new_page: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.action == ACT_PAGE)) |=>
        (orow_reg == 4'd0 && ocol_reg == 4'd0 && !oins_reg && out_valid_reg))
        else $error("new page did not reset cursor state");

    // Only a read returns a cell
    a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.action != ACT_READ)) |=> (cell_reg == 8'h00))
        else $error("cell returned for a non-read word");

endmodule

`default_nettype wire
